// File: rtl/gb5_pkg.sv
// Shared types, constants and helper functions for the 5x5 Gaussian blur.
// Used by the modules under rtl/ other than gb5_ram through scoped names; depends on nothing.
package gb5_pkg;

  // Geometry and arithmetic limits
  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_HEIGHT  = 4096;
  localparam int WEIGHT_BITS = 16;
  localparam int KSIZE       = 5;
  localparam int HALF        = KSIZE / 2;

  // Field widths fixed by the stream and register formats
  localparam int PIX_W      = 8;
  localparam int WGT_W      = 16;
  localparam int FW_CFG_W   = 12;
  localparam int FH_CFG_W   = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Internal widths
  localparam int WID_W    = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W    = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int RC_W     = $clog2(HALF + 2);
  localparam int PROD_W   = PIX_W + WGT_W;
  localparam int COLSUM_W = PROD_W + $clog2(KSIZE);
  localparam int SUM_W    = PROD_W + $clog2(KSIZE * KSIZE);
  localparam int RSUM_W   = (SUM_W + 1 > WEIGHT_BITS + PIX_W + 1) ?
                            SUM_W + 1 : WEIGHT_BITS + PIX_W + 1;
  localparam int RF_W     = $clog2(KSIZE + 1);

  localparam logic [RSUM_W-1:0] ROUND_BIAS = RSUM_W'(1) << (WEIGHT_BITS - 1);

  // Output queue and result pipeline
  localparam int OUTQ_DEPTH  = 8;
  localparam int OUTQ_AW     = $clog2(OUTQ_DEPTH);
  localparam int OQ_CNT_W    = $clog2(OUTQ_DEPTH + 1);
  localparam int PIPE_DEPTH  = 5;
  localparam int OST_W       = $clog2(OUTQ_DEPTH + PIPE_DEPTH + 1);

  // Register reset values
  localparam int RST_FRAME_WIDTH  = 2048;
  localparam int RST_FRAME_HEIGHT = 2048;
  localparam int RST_WIDTH_EFF    = (RST_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH :
                                    RST_FRAME_WIDTH;
  localparam int RST_HEIGHT_EFF   = (RST_FRAME_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT :
                                    RST_FRAME_HEIGHT;

  // Weight classes, one per distinct offset pair
  localparam int NUM_WEIGHTS = 6;
  localparam int W_CENTER = 0;
  localparam int W_D1     = 1;
  localparam int W_DIAG1  = 2;
  localparam int W_D2     = 3;
  localparam int W_KNIGHT = 4;
  localparam int W_CORNER = 5;

  localparam logic [WGT_W-1:0] RST_WEIGHT [NUM_WEIGHTS] =
    '{16'd2674, 16'd2661, 16'd2648, 16'd2621, 16'd2608, 16'd2569};

  // class by |dy|, |dx|
  localparam int WCLASS [HALF+1][HALF+1] = '{
    '{W_CENTER, W_D1,     W_D2},
    '{W_D1,     W_DIAG1,  W_KNIGHT},
    '{W_D2,     W_KNIGHT, W_CORNER}
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_WEIGHT_CENTER = 3'd2,
    REG_WEIGHT_D1     = 3'd3,
    REG_WEIGHT_DIAG1  = 3'd4,
    REG_WEIGHT_D2     = 3'd5,
    REG_WEIGHT_KNIGHT = 3'd6,
    REG_WEIGHT_CORNER = 3'd7
  } cfg_reg_e;

  typedef logic [PIX_W-1:0] sample_t;
  typedef logic [WGT_W-1:0] weight_t;
  typedef sample_t [KSIZE-1:0] column_t;
  typedef weight_t [KSIZE-1:0] weight_col_t;

  typedef struct packed {
    logic             shift;
    logic [KSIZE-1:0] tap_en;
  } cell_ctrl_t;

  typedef struct packed {
    logic    frame_end;
    sample_t blurred;
  } out_item_t;

  // Address bits of line store k, which must hold k rows plus the window span
  function automatic int line_aw(input int k);
    return $clog2(k * MAX_WIDTH + KSIZE);
  endfunction

  // Weight class of the window tap in row k, column j (distances taken from the centre)
  function automatic int tap_class(input int k, input int j);
    int a;
    int b;
    a = (k > HALF) ? k - HALF : HALF - k;
    b = (j > HALF) ? j - HALF : HALF - j;
    return WCLASS[a][b];
  endfunction

  localparam int PTR_W = line_aw(KSIZE - 1);

endpackage

// File: rtl/gaussian_blur_5x5.sv
// Top level of the streaming 5x5 Gaussian blur: counters, line stores,
// a chain of five window cells, the adder and the output queue.
// Depends on gb5_pkg, gb5_ram, gb5_cell and gb5_outq.
//
//  channel  direction  payload (low bit first)       transfer when
//  s_*      in         tdata: pixel, tuser: pad       s_tvalid & s_tready
//  m_*      out        tdata: blurred, tlast: f. end  m_tvalid & m_tready
//  cfg_*    in         cfg_data to register cfg_index cfg_we
//
// One pixel per clock while s_tready is high. A result is formed after the transfer
// of the pixel that completes its window (image position p completes at
// input position p + 2*W + 2). s_tready is low while cfg_we is high, while
// the window reloads from the line stores after a frame_width write, and
// while the output queue plus the result pipeline hold eight.
// Reset is synchronous; the line stores are not cleared.
module gaussian_blur_5x5 (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [gb5_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gb5_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,   // [7:0] pixel
  input  logic [0:0]                         s_tuser,   // [0] pad
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [7:0]                         m_tdata,   // [7:0] blurred
  output logic                               m_tlast    // frame_end
);

  localparam int KSIZE = gb5_pkg::KSIZE;
  localparam int HALF  = gb5_pkg::HALF;
  localparam int WID_W = gb5_pkg::WID_W;
  localparam int HGT_W = gb5_pkg::HGT_W;
  localparam int COL_W = gb5_pkg::COL_W;
  localparam int ROW_W = gb5_pkg::ROW_W;
  localparam int RC_W  = gb5_pkg::RC_W;
  localparam int PTR_W = gb5_pkg::PTR_W;
  localparam int OST_W = gb5_pkg::OST_W;
  localparam logic [RC_W-1:0] RC_MAX = RC_W'(HALF + 1);

  // ---------------- configuration registers
  logic [WID_W-1:0]          frame_w;
  logic [HGT_W-1:0]          frame_h;
  gb5_pkg::weight_t          weight [gb5_pkg::NUM_WEIGHTS];
  logic [gb5_pkg::FW_CFG_W-1:0] w_raw;
  logic [gb5_pkg::FH_CFG_W-1:0] h_raw;
  logic [WID_W-1:0]          w_clamped;
  logic [HGT_W-1:0]          h_clamped;
  logic                      width_wr;

  assign w_raw    = cfg_data[gb5_pkg::FW_CFG_W-1:0];
  assign h_raw    = cfg_data[gb5_pkg::FH_CFG_W-1:0];
  assign width_wr = cfg_we && (gb5_pkg::cfg_reg_e'(cfg_index) == gb5_pkg::REG_FRAME_WIDTH);

  always_comb begin
    if (32'(w_raw) < 32'(KSIZE)) begin
      w_clamped = WID_W'(KSIZE);
    end else if (32'(w_raw) > 32'(gb5_pkg::MAX_WIDTH)) begin
      w_clamped = WID_W'(gb5_pkg::MAX_WIDTH);
    end else begin
      w_clamped = WID_W'(w_raw);
    end
    if (32'(h_raw) < 32'(KSIZE)) begin
      h_clamped = HGT_W'(KSIZE);
    end else if (32'(h_raw) > 32'(gb5_pkg::MAX_HEIGHT)) begin
      h_clamped = HGT_W'(gb5_pkg::MAX_HEIGHT);
    end else begin
      h_clamped = HGT_W'(h_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_w <= WID_W'(gb5_pkg::RST_WIDTH_EFF);
      frame_h <= HGT_W'(gb5_pkg::RST_HEIGHT_EFF);
      for (int i = 0; i < gb5_pkg::NUM_WEIGHTS; i++) begin
        weight[i] <= gb5_pkg::RST_WEIGHT[i];
      end
    end else if (cfg_we) begin
      case (gb5_pkg::cfg_reg_e'(cfg_index))
        gb5_pkg::REG_FRAME_WIDTH:   frame_w <= w_clamped;
        gb5_pkg::REG_FRAME_HEIGHT:  frame_h <= h_clamped;
        gb5_pkg::REG_WEIGHT_CENTER: weight[gb5_pkg::W_CENTER] <= cfg_data;
        gb5_pkg::REG_WEIGHT_D1:     weight[gb5_pkg::W_D1]     <= cfg_data;
        gb5_pkg::REG_WEIGHT_DIAG1:  weight[gb5_pkg::W_DIAG1]  <= cfg_data;
        gb5_pkg::REG_WEIGHT_D2:     weight[gb5_pkg::W_D2]     <= cfg_data;
        gb5_pkg::REG_WEIGHT_KNIGHT: weight[gb5_pkg::W_KNIGHT] <= cfg_data;
        gb5_pkg::REG_WEIGHT_CORNER: weight[gb5_pkg::W_CORNER] <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- input side control
  logic                       acc;
  logic [gb5_pkg::RF_W-1:0]   refill_cnt;
  logic                       refill_active;
  logic [OST_W-1:0]           outstanding;
  logic [gb5_pkg::OQ_CNT_W-1:0] oq_count;
  logic                       a_shift, a_rot, a_emit, a_last;
  logic                       b_emit, b_last, c_emit, c_last, d_emit, d_last;
  logic                       e_emit, e_last;

  assign refill_active = (refill_cnt != '0);
  assign outstanding   = OST_W'(oq_count) + OST_W'(a_emit) + OST_W'(b_emit) +
                         OST_W'(c_emit) + OST_W'(d_emit) + OST_W'(e_emit);
  assign s_tready      = !refill_active && !cfg_we &&
                         (outstanding < OST_W'(gb5_pkg::OUTQ_DEPTH));
  assign acc           = s_tvalid && s_tready;

  // window reload after a width change, reading column distances 4 down to 0
  always_ff @(posedge clk) begin
    if (rst) begin
      refill_cnt <= '0;
    end else if (width_wr) begin
      refill_cnt <= gb5_pkg::RF_W'(KSIZE);
    end else if (refill_active) begin
      refill_cnt <= refill_cnt - 1'b1;
    end
  end

  // ---------------- position counters
  logic [COL_W-1:0]     col_cnt;
  logic [RC_W-1:0]      row_cnt;
  logic [COL_W-1:0]     out_col;
  logic [ROW_W-1:0]     out_row;
  logic                 emit, last, col_wrap, out_col_wrap;
  logic [KSIZE-1:0]     rmask, cmask;
  gb5_pkg::sample_t     sample;

  assign sample = s_tuser[0] ? '0 : s_tdata;

  always_comb begin
    emit = (row_cnt == RC_MAX) ||
           ((row_cnt == RC_W'(HALF)) && (col_cnt >= COL_W'(HALF)));
    col_wrap     = ((WID_W+1)'(col_cnt) + 1'b1) >= (WID_W+1)'(frame_w);
    out_col_wrap = ((WID_W+1)'(out_col) + 1'b1) >= (WID_W+1)'(frame_w);
    last         = out_col_wrap &&
                   (((HGT_W+1)'(out_row) + 1'b1) >= (HGT_W+1)'(frame_h));
    for (int i = 0; i < KSIZE; i++) begin
      rmask[i] = (((HGT_W+1)'(out_row) + (HGT_W+1)'(i)) >= (HGT_W+1)'(HALF)) &&
                 (((HGT_W+1)'(out_row) + (HGT_W+1)'(i)) <
                  ((HGT_W+1)'(frame_h) + (HGT_W+1)'(HALF)));
      cmask[i] = (((WID_W+1)'(out_col) + (WID_W+1)'(i)) >= (WID_W+1)'(HALF)) &&
                 (((WID_W+1)'(out_col) + (WID_W+1)'(i)) <
                  ((WID_W+1)'(frame_w) + (WID_W+1)'(HALF)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (acc) begin
      if (emit && last) begin
        col_cnt <= '0;
        row_cnt <= '0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        if (emit) begin
          if (out_col_wrap) begin
            out_col <= '0;
            out_row <= out_row + 1'b1;
          end else begin
            out_col <= out_col + 1'b1;
          end
        end
        if (col_wrap) begin
          col_cnt <= '0;
          if (row_cnt != RC_MAX) begin
            row_cnt <= row_cnt + 1'b1;
          end
        end else begin
          col_cnt <= col_cnt + 1'b1;
        end
      end
    end
  end

  // ---------------- line stores: copy k returns the sample k rows back
  logic [PTR_W-1:0]  wp;
  logic [PTR_W-1:0]  wp_inc;
  logic [PTR_W-1:0]  rd_base;
  logic [PTR_W-1:0]  rd_off;
  gb5_pkg::sample_t  ls_rdata [1:KSIZE-1];

  assign wp_inc  = wp + 1'b1;
  assign rd_base = refill_active ? wp : wp_inc;
  assign rd_off  = refill_active ? PTR_W'(refill_cnt - 1'b1) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
    end else if (acc) begin
      wp <= wp_inc;
    end
  end

  for (genvar k = 1; k < KSIZE; k++) begin : g_line
    localparam int AW = gb5_pkg::line_aw(k);
    logic [PTR_W-1:0] rd_full;

    assign rd_full = rd_base - (PTR_W'(k) * PTR_W'(frame_w) + rd_off);

    gb5_ram #(
      .WIDTH (gb5_pkg::PIX_W),
      .DEPTH (1 << AW)
    ) u_ram (
      .clk   (clk),
      .we    (acc),
      .waddr (wp_inc[AW-1:0]),
      .wdata (sample),
      .raddr (rd_full[AW-1:0]),
      .rdata (ls_rdata[k])
    );
  end

  // ---------------- stage A / B registers
  gb5_pkg::sample_t   a_sample;
  logic [KSIZE-1:0]   a_rmask, a_cmask, b_rmask, b_cmask;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_shift <= 1'b0;
      a_rot   <= 1'b0;
      a_emit  <= 1'b0;
      b_emit  <= 1'b0;
      c_emit  <= 1'b0;
      d_emit  <= 1'b0;
      e_emit  <= 1'b0;
    end else begin
      a_shift <= acc || refill_active;
      a_rot   <= refill_active;
      a_emit  <= acc && emit;
      b_emit  <= a_emit;
      c_emit  <= b_emit;
      d_emit  <= c_emit;
      e_emit  <= d_emit;
    end
  end

  always_ff @(posedge clk) begin
    a_sample <= sample;
    a_last   <= emit && last;
    a_rmask  <= rmask;
    a_cmask  <= cmask;
    b_last   <= a_last;
    b_rmask  <= a_rmask;
    b_cmask  <= a_cmask;
    c_last   <= b_last;
    d_last   <= c_last;
    e_last   <= d_last;
  end

  // ---------------- window: chain of column cells
  gb5_pkg::column_t      cell_in  [KSIZE];
  gb5_pkg::column_t      cell_col [KSIZE];
  gb5_pkg::weight_col_t  cell_wgt [KSIZE];
  gb5_pkg::cell_ctrl_t   cell_ctrl [KSIZE];
  logic [gb5_pkg::COLSUM_W-1:0] col_sum [KSIZE];

  // during a reload the newest row turns round the chain and ends where it began
  assign cell_in[0][0] = a_rot ? cell_col[KSIZE-1][0] : a_sample;
  for (genvar k = 1; k < KSIZE; k++) begin : g_col0
    assign cell_in[0][k] = ls_rdata[k];
  end

  for (genvar j = 0; j < KSIZE; j++) begin : g_cell
    if (j > 0) begin : g_link
      assign cell_in[j] = cell_col[j-1];
    end
    for (genvar k = 0; k < KSIZE; k++) begin : g_tap
      localparam int CLS = gb5_pkg::tap_class(k, j);
      assign cell_wgt[j][k]         = weight[CLS];
      assign cell_ctrl[j].tap_en[k] = b_rmask[KSIZE-1-k] & b_cmask[KSIZE-1-j];
    end
    assign cell_ctrl[j].shift = a_shift;

    gb5_cell u_cell (
      .clk     (clk),
      .ctrl    (cell_ctrl[j]),
      .weight  (cell_wgt[j]),
      .col_in  (cell_in[j]),
      .col_out (cell_col[j]),
      .col_sum (col_sum[j])
    );
  end

  // ---------------- final sum, rounding and saturation
  logic [gb5_pkg::RSUM_W-1:0] total;
  logic [gb5_pkg::RSUM_W-1:0] e_rsum;
  gb5_pkg::out_item_t         res_item;
  gb5_pkg::out_item_t         oq_head;
  logic                       oq_valid;

  always_comb begin
    total = gb5_pkg::ROUND_BIAS;
    for (int j = 0; j < KSIZE; j++) begin
      total = total + gb5_pkg::RSUM_W'(col_sum[j]);
    end
  end

  always_ff @(posedge clk) begin
    e_rsum <= total;
  end

  always_comb begin
    res_item.frame_end = e_last;
    if (|e_rsum[gb5_pkg::RSUM_W-1:gb5_pkg::WEIGHT_BITS+gb5_pkg::PIX_W]) begin
      res_item.blurred = '1;
    end else begin
      res_item.blurred =
        e_rsum[gb5_pkg::WEIGHT_BITS+gb5_pkg::PIX_W-1:gb5_pkg::WEIGHT_BITS];
    end
  end

  gb5_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (e_emit),
    .push_item (res_item),
    .pop       (m_tready),
    .valid     (oq_valid),
    .head      (oq_head),
    .count     (oq_count)
  );

  assign m_tvalid = oq_valid;
  assign m_tdata  = oq_head.blurred;
  assign m_tlast  = oq_head.frame_end;

  // ---------------- checks
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    outstanding <= OST_W'(gb5_pkg::OUTQ_DEPTH))
    else $error("result queue overrun");

  a_reload_no_result: assert property (@(posedge clk) disable iff (rst)
    a_rot |-> !a_emit)
    else $error("window reload step carries a result");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (acc && emit && last) |=> (out_row == '0 && out_col == '0 &&
                               col_cnt == '0 && row_cnt == '0))
    else $error("counters not cleared after last pixel of frame");

  a_reload_start: assert property (@(posedge clk) disable iff (rst)
    width_wr |=> (refill_cnt == gb5_pkg::RF_W'(KSIZE) && !s_tready))
    else $error("width write did not start window reload");

endmodule

// File: rtl/gb5_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the line stores of the blur; no package dependency.
module gb5_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/gb5_cell.sv
// One column of the 5x5 window: holds five samples, passes them on to the
// next column on a shift, and forms the weighted column sum. Uses gb5_pkg.
module gb5_cell (
  input  logic                           clk,
  input  gb5_pkg::cell_ctrl_t            ctrl,
  input  gb5_pkg::weight_col_t           weight,
  input  gb5_pkg::column_t               col_in,
  output gb5_pkg::column_t               col_out,
  output logic [gb5_pkg::COLSUM_W-1:0]   col_sum
);

  gb5_pkg::column_t                  col;
  logic [gb5_pkg::PROD_W-1:0]        prod [gb5_pkg::KSIZE];
  logic [gb5_pkg::COLSUM_W-1:0]      sum_comb;

  assign col_out = col;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      col <= col_in;
    end
  end

  // taps outside the image contribute nothing
  always_ff @(posedge clk) begin
    for (int k = 0; k < gb5_pkg::KSIZE; k++) begin
      prod[k] <= ctrl.tap_en[k] ?
                 gb5_pkg::PROD_W'(col[k]) * gb5_pkg::PROD_W'(weight[k]) : '0;
    end
  end

  always_comb begin
    sum_comb = '0;
    for (int k = 0; k < gb5_pkg::KSIZE; k++) begin
      sum_comb = sum_comb + gb5_pkg::COLSUM_W'(prod[k]);
    end
  end

  always_ff @(posedge clk) begin
    col_sum <= sum_comb;
  end

endmodule

// File: rtl/gb5_outq.sv
// Small register queue that holds finished results until the sink takes them.
// Uses gb5_pkg for the item type and depth.
module gb5_outq (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  gb5_pkg::out_item_t              push_item,
  input  logic                            pop,
  output logic                            valid,
  output gb5_pkg::out_item_t              head,
  output logic [gb5_pkg::OQ_CNT_W-1:0]    count
);

  gb5_pkg::out_item_t              mem [gb5_pkg::OUTQ_DEPTH];
  logic [gb5_pkg::OUTQ_AW-1:0]     wr_ptr;
  logic [gb5_pkg::OUTQ_AW-1:0]     rd_ptr;
  logic                            do_pop;

  assign valid  = (count != '0);
  assign head   = mem[rd_ptr];
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: sim/gaussian_blur_5x5_test.sv
`timescale 1ns / 1ps
// Self-checking bench for gaussian_blur_5x5: streams frames of grey pixels, some cut short, predicts
// every blurred pixel in a behavioural model and compares each output transfer in order.
// Depends on gb5_pkg and the RTL of the blur.
module gaussian_blur_5x5_test;
  import gb5_pkg::*;

  localparam int     HIST_DEPTH    = 4 * MAX_WIDTH + 8;
  localparam int     SETTLE_CYCLES = 20;
  localparam int     RANDOM_ITEMS  = 1500;
  localparam int     REPORT_LIMIT  = 100;
  localparam longint CYCLE_LIMIT   = 3000000;

  typedef enum int {KERNEL_GAUSS, KERNEL_ANY, KERNEL_MAX, KERNEL_ZERO} kernel_style_e;
  typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_TOGGLE, RX_BURSTY} rx_mode_e;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [7:0]            s_tdata;
  logic [0:0]            s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [7:0]            m_tdata;
  logic                  m_tlast;

  gaussian_blur_5x5 dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  // Behavioural copy of the blur: registers, sample history and stream position
  logic [FW_CFG_W-1:0] width_reg;
  logic [FH_CFG_W-1:0] height_reg;
  weight_t             kernel_wgt [NUM_WEIGHTS];
  sample_t             pixel_hist [HIST_DEPTH];
  int                  hist_pos;
  int                  in_col;
  int                  in_row;
  int                  px_col;
  int                  px_row;
  out_item_t           blur_due [$];

  int errors;
  int items_sent;
  int burst_left;
  int hold_off_len;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void flag_error(input string what);
    errors++;
    if (errors <= REPORT_LIMIT) $display("%0t ns: %s", $time, what);
  endfunction

  function automatic int active_width();
    if (width_reg < 5) return 5;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return int'(width_reg);
  endfunction

  function automatic int active_height();
    if (height_reg < 5) return 5;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return int'(height_reg);
  endfunction

  // Symmetric kernel: the class depends only on the two absolute offsets
  function automatic int kernel_class(input int a, input int b);
    int lo;
    int hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (hi == 0) return W_CENTER;
    if (hi == 1) return (lo == 0) ? W_D1 : W_DIAG1;
    if (lo == 0) return W_D2;
    return (lo == 1) ? W_KNIGHT : W_CORNER;
  endfunction

  function automatic sample_t random_pixel();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return sample_t'($urandom);
  endfunction

  function automatic logic frame_boundary();
    return in_col == 0 && in_row == 0 && px_col == 0 && px_row == 0;
  endfunction

  // Advance the model by one accepted pixel; queue the blurred pixel it completes, if any
  task automatic predict_blur(input sample_t pix, input logic pad);
    int w;
    int h;
    int r;
    int c;
    int dy;
    int dx;
    int lag;
    longint unsigned acc;
    out_item_t res;
    w = active_width();
    h = active_height();
    hist_pos = (hist_pos + 1) % HIST_DEPTH;
    pixel_hist[hist_pos] = pad ? 8'h00 : pix;
    if (in_row > 2 || (in_row == 2 && in_col >= 2)) begin
      acc = 0;
      for (dy = -2; dy <= 2; dy++) begin
        for (dx = -2; dx <= 2; dx++) begin
          r = px_row + dy;
          c = px_col + dx;
          if (r >= 0 && r < h && c >= 0 && c < w) begin
            lag = (2 - dy) * w + (2 - dx);
            acc += longint'(pixel_hist[(hist_pos + HIST_DEPTH - lag) % HIST_DEPTH]) *
                   longint'(kernel_wgt[kernel_class(dy < 0 ? -dy : dy, dx < 0 ? -dx : dx)]);
          end
        end
      end
      acc = (acc + (64'd1 << (WEIGHT_BITS - 1))) >> WEIGHT_BITS;
      res.blurred   = (acc > 255) ? 8'hFF : acc[7:0];
      res.frame_end = (px_row + 1 >= h) && (px_col + 1 >= w);
      blur_due.push_back(res);
      if (res.frame_end) begin
        in_col = 0;
        in_row = 0;
        px_col = 0;
        px_row = 0;
        return;
      end
      if (px_col + 1 >= w) begin
        px_col = 0;
        px_row++;
      end else begin
        px_col++;
      end
    end
    if (in_col + 1 >= w) begin
      in_col = 0;
      in_row++;
    end else begin
      in_col++;
    end
  endtask

  // One input transfer; bursts of random length separated by random gaps
  task automatic send_item(input sample_t pix, input logic pad);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 400) : $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        s_tdata  <= sample_t'($urandom);
        s_tuser  <= 1'($urandom);
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    s_tuser  <= pad;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    predict_blur(pix, pad);
  endtask

  // Sender stops until every expected pixel is out and the pipeline has settled
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (blur_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_FRAME_WIDTH:  width_reg  = value[FW_CFG_W-1:0];
      REG_FRAME_HEIGHT: height_reg = value[FH_CFG_W-1:0];
      default:          kernel_wgt[int'(idx) - int'(REG_WEIGHT_CENTER)] = value[WGT_W-1:0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Bits above the register width carry junk; the block keeps only the low bits
  task automatic set_geometry(input int w, input int h);
    logic [CFG_DATA_W-1:0] v;
    v = CFG_DATA_W'($urandom);
    v[FW_CFG_W-1:0] = w[FW_CFG_W-1:0];
    cfg_write(REG_FRAME_WIDTH, v);
    v = CFG_DATA_W'($urandom);
    v[FH_CFG_W-1:0] = h[FH_CFG_W-1:0];
    cfg_write(REG_FRAME_HEIGHT, v);
  endtask

  task automatic load_kernel(input kernel_style_e style);
    weight_t v;
    int k;
    for (k = 0; k < NUM_WEIGHTS; k++) begin
      case (style)
        KERNEL_GAUSS: v = weight_t'($urandom_range(0, 5300));
        KERNEL_ANY:   v = weight_t'($urandom);
        KERNEL_MAX:   v = '1;
        default:      v = '0;
      endcase
      cfg_write(cfg_reg_e'(int'(REG_WEIGHT_CENTER) + k), v);
    end
  endtask

  // Pads, with a pixel now and then, until the last blurred pixel of the frame is due
  task automatic flush_frame();
    while (!frame_boundary()) send_item(sample_t'($urandom), $urandom_range(0, 3) != 0);
  endtask

  // Image pixels (cut short when cut is in range), then the flush
  task automatic send_frame(input int pad_pct, input int cut);
    int n;
    int i;
    n = active_width() * active_height();
    if (cut >= 0 && cut < n) n = cut;
    for (i = 0; i < n; i++) send_item(random_pixel(), $urandom_range(0, 99) < pad_pct);
    flush_frame();
  endtask

  // Smallest frame with the reset kernel: border zeros, a pad inside the image and
  // pixel transfers in the flush region that must not reach any output
  task automatic test_directed_frame();
    int i;
    wait_drained();
    set_geometry(0, 2);
    for (i = 0; i < 25; i++) begin
      case (i % 3)
        0:       send_item(8'hFF, i == 12);
        1:       send_item(8'h00, 1'b0);
        default: send_item(8'h5A + sample_t'(i), 1'b0);
      endcase
    end
    for (i = 0; i < 2 * 5 + 2; i++) send_item(8'hFF, i[0]);
  endtask

  // Long output stall fills the block; then a mid-frame pause with a kernel reload
  task automatic test_pressure();
    int n;
    int i;
    wait_drained();
    set_geometry(16, 8);
    load_kernel(KERNEL_GAUSS);
    n = active_width() * active_height();
    for (i = 0; i < n; i++) begin
      if (i == 30) hold_off_len = 400;
      if (i == 90) begin
        wait_drained();
        load_kernel(KERNEL_GAUSS);
      end
      send_item(random_pixel(), 1'b0);
    end
    flush_frame();
  endtask

  task automatic test_random_frames();
    int start;
    int frame_no;
    int w;
    int h;
    int cut;
    int pick;
    kernel_style_e style;
    start = items_sent;
    frame_no = 0;
    while (items_sent - start < RANDOM_ITEMS) begin
      wait_drained();
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        // below the geometry floor
        w = $urandom_range(0, 4);
        h = $urandom_range(0, 4);
      end else if (pick < 3) begin
        w = $urandom_range(17, 96);
        h = $urandom_range(5, 7);
      end else begin
        w = $urandom_range(5, 16);
        h = $urandom_range(5, 10);
      end
      set_geometry(w, h);
      pick = $urandom_range(0, 9);
      if (frame_no == 0 || pick == 8) style = KERNEL_MAX;
      else if (frame_no == 1 || pick == 9) style = KERNEL_ZERO;
      else if (pick < 6) style = KERNEL_GAUSS;
      else style = KERNEL_ANY;
      load_kernel(style);
      if ($urandom_range(0, 14) == 0) hold_off_len = $urandom_range(50, 300);
      cut = ($urandom_range(0, 6) == 0) ? $urandom_range(0, active_width() * active_height()) : -1;
      send_frame($urandom_range(0, 1) ? 0 : $urandom_range(1, 20), cut);
      frame_no++;
    end
  endtask

  // Register values at the geometry floor: one side exactly five, the other below it
  task automatic test_geometry_limits();
    wait_drained();
    set_geometry(5, 4);
    load_kernel(KERNEL_GAUSS);
    send_frame(2, -1);
    wait_drained();
    set_geometry(3, 5);
    load_kernel(KERNEL_GAUSS);
    send_frame(2, -1);
  endtask

  // Output side: stall pattern picked at random from five modes, plus requested hold-offs
  initial begin : receiver
    rx_mode_e mode;
    int left;
    int hold;
    int phase;
    m_tready = 1'b0;
    mode = RX_OPEN;
    left = 0;
    hold = 0;
    phase = 0;
    forever begin
      @(negedge clk);
      if (hold_off_len > 0) begin
        hold = hold_off_len;
        hold_off_len = 0;
      end
      if (left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 4));
        left = $urandom_range(20, 300);
      end
      left--;
      phase++;
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          RX_OPEN:   m_tready <= 1'b1;
          RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
          RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
          RX_TOGGLE: m_tready <= phase[0];
          default:   m_tready <= (phase % 8) < 3;
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t due;
    if (!rst && m_tvalid && m_tready) begin
      if (blur_due.size() == 0) begin
        flag_error($sformatf("unexpected transfer: expected none, got blurred %0d frame_end %0d",
                             m_tdata, m_tlast));
      end else begin
        due = blur_due.pop_front();
        if (m_tdata !== due.blurred)
          flag_error($sformatf("blurred: expected %0d, got %0d", due.blurred, m_tdata));
        if (m_tlast !== due.frame_end)
          flag_error($sformatf("frame_end: expected %0d, got %0d", due.frame_end, m_tlast));
      end
    end
  end

  initial begin : watchdog
    longint cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int i;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    errors       = 0;
    items_sent   = 0;
    burst_left   = 0;
    hold_off_len = 0;
    width_reg  = FW_CFG_W'(RST_FRAME_WIDTH);
    height_reg = FH_CFG_W'(RST_FRAME_HEIGHT);
    kernel_wgt = RST_WEIGHT;
    for (i = 0; i < HIST_DEPTH; i++) pixel_hist[i] = '0;
    hist_pos = 0;
    in_col   = 0;
    in_row   = 0;
    px_col   = 0;
    px_row   = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_frame();
    test_pressure();
    test_random_frames();
    test_geometry_limits();
    wait_drained();

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
